/* sv/lms_pkg.sv */
// ----------------------------------------------------------------------------
// lms_pkg
// Shared constants for the LMS adaptive FIR filter.
// ----------------------------------------------------------------------------
package lms_pkg;

  localparam int TAPS_DEFAULT = 32;

  localparam int SAMPLE_W = 16;  // Q1.15
  localparam int WEIGHT_W = 24;  // Q4.20
  localparam int STEP_W   = 16;  // Q0.16
  localparam int DATA_W   = 2 * SAMPLE_W;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_STEP_SIZE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ERROR_MODE = 2'd1;

  localparam logic [STEP_W-1:0]   STEP_RESET  = 16'd655;
  localparam logic [WEIGHT_W-1:0] WEIGHT_INIT = 24'd943718;  // 0.9 in Q4.20

endpackage

/* sv/lms_ram.sv */
// ----------------------------------------------------------------------------
// lms_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/lms_adaptive_fir.sv */
// ----------------------------------------------------------------------------
// lms_adaptive_fir
// LMS adaptive FIR filter with RAM-based delay line and tap weights.
// ----------------------------------------------------------------------------
// Each request carries a reference sample and a second sample (desired signal,
// or measured error when error_mode is set) and yields one result: the filter
// output and the error used for adaptation. Samples and weights live in two
// RAMs that are walked one tap per cycle. An item runs through these steps
// in order: the accept, one pass of TAPS reads for the dot product and its
// pipeline drain, the error and the step product, then one
// read-modify-write pass of TAPS for the weight update and its drain.
// A result still pending at the output stalls the error cycle until it is
// taken. After reset the block clears both RAMs (weight 0 is loaded with
// 0.9) before it takes its first request; configuration writes are accepted
// at any time but should only be issued while the block is idle.
// The result sits in an output register, so the next request is accepted
// while an earlier result still waits.
// ----------------------------------------------------------------------------
module lms_adaptive_fir #(
  parameter int TAPS = lms_pkg::TAPS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // s_axis_tdata: [15:0] reference_sample, [31:16] second_sample
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lms_pkg::DATA_W-1:0]    s_axis_tdata,
  // m_axis_tdata: [15:0] filter_out, [31:16] error_out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lms_pkg::DATA_W-1:0]    m_axis_tdata,
  input  logic                          cfg_we,
  input  logic [lms_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lms_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import lms_pkg::*;

  localparam int AW    = $clog2(TAPS);
  localparam int ACC_W = AW + 20;
  localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_FILT   = 3'd2;
  localparam logic [2:0] ST_FDRAIN = 3'd3;
  localparam logic [2:0] ST_ERR    = 3'd4;
  localparam logic [2:0] ST_STEP   = 3'd5;
  localparam logic [2:0] ST_UPD    = 3'd6;
  localparam logic [2:0] ST_UDRAIN = 3'd7;

  logic [2:0]    state;
  logic [AW-1:0] idx;
  logic [AW-1:0] kidx;
  logic [AW-1:0] pos;
  logic [AW-1:0] a1;
  logic [AW-1:0] a2;
  logic          v1;
  logic          v2;

  logic [STEP_W-1:0] step_size;
  logic              error_mode;

  logic signed [SAMPLE_W-1:0] second_r;
  logic signed [ACC_W-1:0]    acc;
  logic signed [SAMPLE_W-1:0] err_r;
  logic signed [16:0]         p;
  logic signed [39:0]         fprod;
  logic signed [32:0]         dprod;
  logic signed [WEIGHT_W-1:0] wgt_d;

  logic                       s_we;
  logic [AW-1:0]              s_waddr;
  logic [SAMPLE_W-1:0]        s_wdata;
  logic [SAMPLE_W-1:0]        s_rdata;
  logic                       w_we;
  logic [AW-1:0]              w_waddr;
  logic [WEIGHT_W-1:0]        w_wdata;
  logic [WEIGHT_W-1:0]        w_rdata;

  logic                       accept;
  logic                       issue;
  logic                       upd_phase;
  logic                       out_load;
  logic [AW-1:0]              kidx_dec;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic signed [16:0]         diff;
  logic signed [SAMPLE_W-1:0] diff_sat;
  logic signed [SAMPLE_W-1:0] err_val;
  logic signed [24:0]         wsum;
  logic [WEIGHT_W-1:0]        wsat;
  logic signed [32:0]         pfull;

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  lms_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_sample_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (kidx),
    .rdata (s_rdata)
  );

  lms_ram #(.WIDTH(WEIGHT_W), .DEPTH(TAPS)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (idx),
    .rdata (w_rdata)
  );

  // ---------------------------------------------------------------------------
  // Control decode and datapath
  // ---------------------------------------------------------------------------
  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign issue         = (state == ST_FILT) || (state == ST_UPD);
  assign upd_phase     = (state == ST_UPD) || (state == ST_UDRAIN);
  assign out_load      = (state == ST_ERR) && (!m_axis_tvalid || m_axis_tready);
  assign kidx_dec      = (kidx == '0) ? LAST : kidx - AW'(1);
  assign pfull         = $signed({1'b0, step_size}) * err_r;

  always_comb begin
    // y saturates when the bits above the sign of a 16-bit value disagree
    if (acc[ACC_W-1:15] == '0 || acc[ACC_W-1:15] == '1) begin
      y_sat = acc[15:0];
    end else begin
      y_sat = acc[ACC_W-1] ? 16'sh8000 : 16'sh7fff;
    end

    diff = {second_r[15], second_r} - {y_sat[15], y_sat};
    if (diff[16] == diff[15]) begin
      diff_sat = diff[15:0];
    end else begin
      diff_sat = diff[16] ? 16'sh8000 : 16'sh7fff;
    end
    err_val = error_mode ? second_r : diff_sat;

    wsum = {wgt_d[WEIGHT_W-1], wgt_d} + {{2{dprod[32]}}, dprod[32:10]};
    if (wsum[24] == wsum[23]) begin
      wsat = wsum[23:0];
    end else begin
      wsat = wsum[24] ? 24'h800000 : 24'h7fffff;
    end
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      s_we    = 1'b1;
      s_waddr = idx;
      s_wdata = '0;
      w_we    = 1'b1;
      w_waddr = idx;
      w_wdata = (idx == '0) ? WEIGHT_INIT : '0;
    end else begin
      s_we    = accept;
      s_waddr = pos;
      s_wdata = s_axis_tdata[SAMPLE_W-1:0];
      w_we    = v2 && upd_phase;
      w_waddr = a2;
      w_wdata = wsat;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size  <= STEP_RESET;
      error_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_STEP_SIZE:  step_size  <= cfg_wdata[STEP_W-1:0];
        REG_ERROR_MODE: error_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      idx   <= '0;
      pos   <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      unique case (state)
        ST_CLEAR: begin
          if (idx == LAST) begin
            idx   <= '0;
            state <= ST_IDLE;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            idx   <= '0;
            state <= ST_FILT;
          end
        end
        ST_FILT, ST_UPD: begin
          if (idx == LAST) begin
            idx   <= '0;
            state <= (state == ST_FILT) ? ST_FDRAIN : ST_UDRAIN;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        ST_FDRAIN: begin
          if (!v1 && !v2) begin
            state <= ST_ERR;
          end
        end
        ST_ERR: begin
          if (out_load) begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          state <= ST_UPD;
        end
        ST_UDRAIN: begin
          if (!v1 && !v2) begin
            pos   <= (pos == LAST) ? '0 : pos + AW'(1);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // back index walks down from the write position, wrapping from zero to the top
  always_ff @(posedge clk) begin
    if (accept || state == ST_STEP) begin
      kidx <= pos;
    end else if (issue) begin
      kidx <= kidx_dec;
    end
  end

  // ---------------------------------------------------------------------------
  // Arithmetic pipeline
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      second_r <= s_axis_tdata[DATA_W-1:SAMPLE_W];
    end
    a1 <= idx;
    a2 <= a1;
    fprod <= $signed(w_rdata) * $signed(s_rdata);
    dprod <= p * $signed(s_rdata);
    wgt_d <= w_rdata;
    if (state == ST_FILT && idx == '0) begin
      acc <= '0;
    end else if (v2 && !upd_phase) begin
      acc <= acc + ACC_W'($signed(fprod[39:20]));
    end
    if (out_load) begin
      err_r <= err_val;
    end
    if (state == ST_STEP) begin
      p <= pfull[32:16];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {err_val, y_sat};
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_wwrite_in_filter: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILT || state == ST_FDRAIN) |-> !w_we)
    else $error("weight write during filter pass");

  a_out_free_on_load: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten while pending");

  a_pos_moves_at_end: assert property (@(posedge clk) disable iff (rst)
    (pos != $past(pos)) |-> ($past(state) == ST_UDRAIN))
    else $error("write position moved outside end of item");

  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    v2 |-> $past(v1))
    else $error("pipeline stage valid without predecessor");

endmodule

/* bench/tb_lms_adaptive_fir.sv */
// ----------------------------------------------------------------------------
// tb_lms_adaptive_fir
// Self-checking bench for the LMS adaptive FIR filter.
// ----------------------------------------------------------------------------
// Each accepted request runs through a bit-exact software copy of the filter:
// delay line, Q4.20 tap weights, saturation and update rules. That copy
// predicts filter_out and error_out. The monitor compares every returned
// result with the oldest prediction. A short directed run covers sample
// extremes, both error modes, output saturation, weight saturation, unused
// register indexes and ignored upper register bits. Random phases follow,
// each with its own step size and mode. Both stream sides idle in random
// bursts, and the final phase runs with no idling.
// ----------------------------------------------------------------------------
module tb_lms_adaptive_fir;
  timeunit 1ns;
  timeprecision 1ps;

  import lms_pkg::*;

  localparam int TAPS         = TAPS_DEFAULT;
  localparam int SETTLE_TICKS = 2 * TAPS + 20;
  localparam int ITEMS_PER_PHASE = 215;

  // indexes with no register behind them
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 2'd3;

  localparam longint Q15_MAX    = 32767;
  localparam longint Q15_MIN    = -32768;
  localparam longint WEIGHT_MAX = 8388607;
  localparam longint WEIGHT_MIN = -8388608;

  localparam logic [SAMPLE_W-1:0] S_MAX  = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] S_MIN  = 16'h8000;
  localparam logic [SAMPLE_W-1:0] S_ZERO = 16'h0000;

  // packed in tdata order: filter_out in the low half
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] error_out;
    logic signed [SAMPLE_W-1:0] filter_out;
  } fir_result_t;

  class lms_scoreboard;
    longint      delay_line[TAPS];
    longint      weights[TAPS];
    int unsigned head;
    longint      step_size;
    bit          acoustic;
    fir_result_t expected_results[$];
    int          mismatches;

    function new();
      foreach (delay_line[i]) begin
        delay_line[i] = 0;
        weights[i]    = 0;
      end
      weights[0] = WEIGHT_INIT;
      head       = 0;
      step_size  = STEP_RESET;
      acoustic   = 1'b0;
      mismatches = 0;
    endfunction

    static function longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void set_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_STEP_SIZE:  step_size = val;
        REG_ERROR_MODE: acoustic  = val[0];
        default: ;
      endcase
    endfunction

    function void note_request(logic [DATA_W-1:0] data);
      shortint     ref_in;
      shortint     second_in;
      longint      acc;
      longint      y;
      longint      err;
      longint      p;
      longint      delta;
      int unsigned k;
      fir_result_t r;
      ref_in    = data[15:0];
      second_in = data[31:16];
      delay_line[head] = ref_in;

      acc = 0;
      for (int i = 0; i < TAPS; i++) begin
        k = (head + TAPS - i) % TAPS;
        acc += (weights[i] * delay_line[k]) >>> 20;
      end
      y = clamp(acc, Q15_MIN, Q15_MAX);

      // desired mode works from the saturated output
      if (acoustic) err = second_in;
      else          err = clamp(second_in - y, Q15_MIN, Q15_MAX);

      p = (step_size * err) >>> 16;
      for (int i = 0; i < TAPS; i++) begin
        k = (head + TAPS - i) % TAPS;
        delta = (p * delay_line[k]) >>> 10;
        weights[i] = clamp(weights[i] + delta, WEIGHT_MIN, WEIGHT_MAX);
      end
      head = (head + 1) % TAPS;

      r.filter_out = y[15:0];
      r.error_out  = err[15:0];
      expected_results.push_back(r);
    endfunction

    function void report(string what, int want, int got);
      mismatches++;
      $display("%0t %s: expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_result(logic [DATA_W-1:0] data);
      fir_result_t got;
      fir_result_t want;
      got = data;
      if (expected_results.size() == 0) begin
        report("result with nothing pending, filter_out", 0, got.filter_out);
        return;
      end
      want = expected_results.pop_front();
      if (got.filter_out !== want.filter_out)
        report("filter_out mismatch", want.filter_out, got.filter_out);
      if (got.error_out !== want.error_out)
        report("error_out mismatch", want.error_out, got.error_out);
    endfunction
  endclass

  logic                  clk;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [DATA_W-1:0]     s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [DATA_W-1:0]     m_axis_tdata;
  logic                  cfg_we        = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

  bit            idling_on = 1'b0;
  lms_scoreboard sb        = new();

  lms_adaptive_fir #(
    .TAPS(TAPS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("TB_ERROR");
    $finish;
  end

  // output-side backpressure
  initial begin
    forever begin
      @(posedge clk);
      if (idling_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata);
  end

  task automatic send_request(input logic [SAMPLE_W-1:0] ref_in,
                              input logic [SAMPLE_W-1:0] second_in);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {second_in, ref_in};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request({second_in, ref_in});
  endtask

  task automatic write_register(input logic [CFG_ADDR_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_register(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending, wait until every pending result is back and the
  // weight update of the last request has finished
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? S_MAX : S_MIN;
      1, 2:    return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] step_word;
    logic [CFG_DATA_W-1:0] mode_word;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings, desired mode
    send_request(S_ZERO, S_ZERO);
    send_request(S_MAX, S_MAX);
    send_request(S_MIN, S_MIN);
    send_request(S_MAX, S_MIN);
    send_request(S_MIN, S_MAX);
    send_request(16'h0001, 16'hFFFF);
    drain_results();

    // acoustic mode at full step: weights and output run into saturation;
    // bits above error_mode's width must be dropped
    write_register(REG_ERROR_MODE, 16'h8001);
    write_register(REG_STEP_SIZE, 16'hFFFF);
    repeat (6) send_request(S_MAX, S_MAX);
    send_request(S_MIN, S_MAX);
    send_request(S_MAX, S_MIN);
    drain_results();

    // back to desired mode with the output still saturated;
    // writes to unused indexes must change nothing
    write_register(REG_ERROR_MODE, 16'hFFFE);
    write_register(REG_SPARE_A, 16'h1234);
    write_register(REG_SPARE_B, 16'hFFFF);
    send_request(S_MAX, S_MIN);
    send_request(S_MIN, S_MAX);
    send_request(S_MAX, S_MAX);
    send_request(S_ZERO, S_ZERO);

    for (int phase = 0; phase < 6; phase++) begin
      drain_results();
      case (phase)
        0: begin
          step_word = 16'h0000;
          mode_word = 16'($urandom) & 16'hFFFE;
        end
        1: begin
          step_word = 16'hFFFF;
          mode_word = 16'h0000;
        end
        2: begin
          step_word = 16'($urandom);
          mode_word = 16'($urandom) | 16'h0001;
        end
        3: begin
          step_word = 16'($urandom_range(1, 4000));
          mode_word = 16'h0000;
        end
        4: begin
          step_word = 16'hFFFF;
          mode_word = 16'h0001;
        end
        default: begin
          step_word = 16'($urandom);
          mode_word = 16'($urandom);
        end
      endcase
      write_register(REG_STEP_SIZE, step_word);
      write_register(REG_ERROR_MODE, mode_word);
      idling_on = (phase != 5);
      repeat (ITEMS_PER_PHASE) send_request(random_sample(), random_sample());
    end

    drain_results();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
